// File: hdl/fun_pkg.sv
// fun_pkg: shared widths and pipeline beat types for the face normal unit.
// No dependencies; used by the cell modules and the top level.
package fun_pkg;

    localparam int COORD_W   = 16;
    localparam int FRAC_BITS = 14;
    localparam int COUNT_W   = 9;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int MAG_W     = PROD_W;            // |a*b - c*d| < 2^(PROD_W-1)
    localparam int SQ_W      = 2 * MAG_W;
    localparam int ROOT_W    = MAG_W + 1;         // sqrt of a sum of three squares
    localparam int SUM_W     = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 4;
    localparam int QUOT_W    = FRAC_BITS + 2;
    localparam int NUM_W     = MAG_W + FRAC_BITS;
    localparam int DEN_W     = ROOT_W + QUOT_W - 1;
    localparam int OUT_W     = 16;
    localparam int IN_TDATA_W  = 160;
    localparam int OUT_TDATA_W = 48;

    typedef struct packed {
        logic [SUM_W-1:0]        rad;
        logic [REM_W-1:0]        rem;
        logic [ROOT_W-1:0]       root;
        logic [2:0][MAG_W-1:0]   mag;
        logic [2:0]              neg;
    } sqrt_beat_t;

    typedef struct packed {
        logic [2:0][NUM_W-1:0]   num;
        logic [2:0][QUOT_W-1:0]  quot;
        logic [DEN_W-1:0]        den;
        logic [2:0]              neg;
    } div_beat_t;

endpackage

// File: hdl/fun_sqrt_cell.sv
// fun_sqrt_cell: one restoring square-root digit, resolving one root bit a beat.
// Depends on fun_pkg.
module fun_sqrt_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  fun_pkg::sqrt_beat_t  in_beat,
    output logic                 out_valid,
    output fun_pkg::sqrt_beat_t  out_beat
);
    logic                       valid_reg;
    fun_pkg::sqrt_beat_t        beat_reg, beat_next;
    logic [fun_pkg::REM_W-1:0]  cur, trial;

    always_comb begin
        beat_next = in_beat;
        cur   = {in_beat.rem[fun_pkg::REM_W-3:0], in_beat.rad[fun_pkg::SUM_W-1 -: 2]};
        trial = {2'b00, in_beat.root, 2'b01};
        beat_next.rad = {in_beat.rad[fun_pkg::SUM_W-3:0], 2'b00};
        if (cur >= trial) begin
            beat_next.rem  = cur - trial;
            beat_next.root = {in_beat.root[fun_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            beat_next.rem  = cur;
            beat_next.root = {in_beat.root[fun_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;
endmodule

// File: hdl/fun_div_cell.sv
// fun_div_cell: one restoring division step for all three components.
// Depends on fun_pkg.
module fun_div_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  fun_pkg::div_beat_t  in_beat,
    output logic                out_valid,
    output fun_pkg::div_beat_t  out_beat
);
    logic                valid_reg;
    fun_pkg::div_beat_t  beat_reg, beat_next;

    always_comb begin
        beat_next = in_beat;
        for (int i = 0; i < 3; i++) begin
            if (in_beat.den <= fun_pkg::DEN_W'(in_beat.num[i])) begin
                beat_next.num[i]  = in_beat.num[i] - fun_pkg::NUM_W'(in_beat.den);
                beat_next.quot[i] = {in_beat.quot[i][fun_pkg::QUOT_W-2:0], 1'b1};
            end else begin
                beat_next.quot[i] = {in_beat.quot[i][fun_pkg::QUOT_W-2:0], 1'b0};
            end
        end
        beat_next.den = in_beat.den >> 1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;
endmodule

// File: hdl/face_unit_normal_unit.sv
// face_unit_normal_unit: top level, cross product front end plus sqrt and divider cell rows.
// Depends on fun_pkg, fun_sqrt_cell and fun_div_cell.
//
// One face enters per beat on the s_ channel; one unit normal leaves per beat on m_.
// Front end: edge differences, six 17x17 products, cross terms, squares and their
// sum, one register stage each. While the pipeline advances, a row of 35
// square-root cells then resolves one root bit per cycle, and a row of 16 divider
// cells resolves one quotient bit of all three components per cycle. A final
// register applies sign and clamp. Throughput: one face per cycle, only while
// the pipeline is not stalled; every cell then takes a new beat each cycle.
// The whole pipeline advances together: it stalls only while an output beat
// waits and m_tready is low, and s_tready is low exactly then.
// Faces with fewer than three vertices are zeroed at entry and give a zero
// normal; a zero length is taken as one.
// Reset clears all valid bits; no output beat follows until new input.
module face_unit_normal_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // vertex_count, first_x/y/z, second_x/y/z, third_x/y/z, zero pad
    input  logic [fun_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // normal_x, normal_y, normal_z
    output logic [fun_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    localparam int CW = fun_pkg::COORD_W;
    localparam int CB = fun_pkg::COUNT_W;

    logic en;
    logic m_valid_reg;
    logic [fun_pkg::OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // vertex fields
    logic [CB-1:0] vcount;
    logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    assign vcount = s_tdata[CB-1:0];
    assign ax = s_tdata[CB+0*CW +: CW];
    assign ay = s_tdata[CB+1*CW +: CW];
    assign az = s_tdata[CB+2*CW +: CW];
    assign bx = s_tdata[CB+3*CW +: CW];
    assign by = s_tdata[CB+4*CW +: CW];
    assign bz = s_tdata[CB+5*CW +: CW];
    assign cx = s_tdata[CB+6*CW +: CW];
    assign cy = s_tdata[CB+7*CW +: CW];
    assign cz = s_tdata[CB+8*CW +: CW];

    // stage 1: edge vectors
    logic v1_reg;
    logic signed [fun_pkg::DIFF_W-1:0] ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    logic signed [fun_pkg::DIFF_W-1:0] ux_next, uy_next, uz_next, vx_next, vy_next, vz_next;
    logic few;

    always_comb begin
        few = vcount < CB'(3);
        ux_next = few ? '0 : fun_pkg::DIFF_W'(ax) - fun_pkg::DIFF_W'(bx);
        uy_next = few ? '0 : fun_pkg::DIFF_W'(ay) - fun_pkg::DIFF_W'(by);
        uz_next = few ? '0 : fun_pkg::DIFF_W'(az) - fun_pkg::DIFF_W'(bz);
        vx_next = few ? '0 : fun_pkg::DIFF_W'(bx) - fun_pkg::DIFF_W'(cx);
        vy_next = few ? '0 : fun_pkg::DIFF_W'(by) - fun_pkg::DIFF_W'(cy);
        vz_next = few ? '0 : fun_pkg::DIFF_W'(bz) - fun_pkg::DIFF_W'(cz);
    end

    // stage 2: products
    logic v2_reg;
    logic signed [fun_pkg::PROD_W-1:0] p_reg [0:5];

    // stage 3: cross terms as sign and magnitude
    logic v3_reg;
    logic [2:0][fun_pkg::MAG_W-1:0] mag3_reg;
    logic [2:0]                     neg3_reg;
    logic signed [fun_pkg::PROD_W:0] n_diff [0:2];
    logic [2:0][fun_pkg::MAG_W-1:0] mag3_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_diff[i] = (fun_pkg::PROD_W+1)'(p_reg[2*i])
                      - (fun_pkg::PROD_W+1)'(p_reg[2*i+1]);
            mag3_next[i] = n_diff[i][fun_pkg::PROD_W] ?
                           fun_pkg::MAG_W'(-n_diff[i]) : fun_pkg::MAG_W'(n_diff[i]);
        end
    end

    // stage 4: squares; stage 5: sum
    logic v4_reg, v5_reg;
    logic [fun_pkg::SQ_W-1:0] sq_reg [0:2];
    logic [2:0][fun_pkg::MAG_W-1:0] mag4_reg, mag5_reg;
    logic [2:0] neg4_reg, neg5_reg;
    logic [fun_pkg::SUM_W-1:0] sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ux_reg <= ux_next;
            uy_reg <= uy_next;
            uz_reg <= uz_next;
            vx_reg <= vx_next;
            vy_reg <= vy_next;
            vz_reg <= vz_next;
            p_reg[0] <= uy_reg * vz_reg;
            p_reg[1] <= uz_reg * vy_reg;
            p_reg[2] <= uz_reg * vx_reg;
            p_reg[3] <= ux_reg * vz_reg;
            p_reg[4] <= ux_reg * vy_reg;
            p_reg[5] <= uy_reg * vx_reg;
            mag3_reg <= mag3_next;
            for (int i = 0; i < 3; i++) begin
                neg3_reg[i] <= n_diff[i][fun_pkg::PROD_W];
                sq_reg[i]   <= mag3_reg[i] * mag3_reg[i];
            end
            mag4_reg <= mag3_reg;
            neg4_reg <= neg3_reg;
            sum_reg  <= fun_pkg::SUM_W'(sq_reg[0]) + fun_pkg::SUM_W'(sq_reg[1])
                      + fun_pkg::SUM_W'(sq_reg[2]);
            mag5_reg <= mag4_reg;
            neg5_reg <= neg4_reg;
        end
    end

    // square-root cell row
    fun_pkg::sqrt_beat_t sq_beat  [0:fun_pkg::ROOT_W];
    logic                sq_valid [0:fun_pkg::ROOT_W];

    always_comb begin
        sq_beat[0].rad  = sum_reg;
        sq_beat[0].rem  = '0;
        sq_beat[0].root = '0;
        sq_beat[0].mag  = mag5_reg;
        sq_beat[0].neg  = neg5_reg;
        sq_valid[0]     = v5_reg;
    end

    for (genvar g = 0; g < fun_pkg::ROOT_W; g++) begin : g_sqrt
        fun_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sq_valid[g]),
            .in_beat   (sq_beat[g]),
            .out_valid (sq_valid[g+1]),
            .out_beat  (sq_beat[g+1])
        );
    end

    // divider cell row
    fun_pkg::div_beat_t dv_beat  [0:fun_pkg::QUOT_W];
    logic               dv_valid [0:fun_pkg::QUOT_W];
    logic [fun_pkg::ROOT_W-1:0] len;

    always_comb begin
        len = sq_beat[fun_pkg::ROOT_W].root;
        if (len == '0) begin
            len = fun_pkg::ROOT_W'(1);
        end
        for (int i = 0; i < 3; i++) begin
            dv_beat[0].num[i]  = {sq_beat[fun_pkg::ROOT_W].mag[i],
                                  fun_pkg::FRAC_BITS'(0)};
            dv_beat[0].quot[i] = '0;
        end
        dv_beat[0].den = {len, (fun_pkg::QUOT_W-1)'(0)};
        dv_beat[0].neg = sq_beat[fun_pkg::ROOT_W].neg;
        dv_valid[0]    = sq_valid[fun_pkg::ROOT_W];
    end

    for (genvar g = 0; g < fun_pkg::QUOT_W; g++) begin : g_div
        fun_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv_valid[g]),
            .in_beat   (dv_beat[g]),
            .out_valid (dv_valid[g+1]),
            .out_beat  (dv_beat[g+1])
        );
    end

    // sign and clamp into the output register
    logic [fun_pkg::QUOT_W-1:0] q;
    logic [fun_pkg::OUT_W-1:0]  qc;

    always_comb begin
        m_data_next = '0;
        for (int i = 0; i < 3; i++) begin
            q = dv_beat[fun_pkg::QUOT_W].quot[i];
            if (dv_beat[fun_pkg::QUOT_W].neg[i]) begin
                qc = (q > fun_pkg::QUOT_W'(32768)) ? 16'h8000 : fun_pkg::OUT_W'(q);
                m_data_next[i*fun_pkg::OUT_W +: fun_pkg::OUT_W] = -qc;
            end else begin
                qc = (q > fun_pkg::QUOT_W'(32767)) ? 16'h7FFF : fun_pkg::OUT_W'(q);
                m_data_next[i*fun_pkg::OUT_W +: fun_pkg::OUT_W] = qc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_valid[fun_pkg::QUOT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
endmodule
